@@ rtl/wsfr_pkg.sv @@
// Shared types and constants for the websocket frame receiver.
package wsfr_pkg;

  // Input item: command and received byte
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
    logic [6:0] ping_length;
  } out_item_t;

  // Result from the parser with its valid flag
  typedef struct packed {
    logic      vld;
    out_item_t item;
  } result_t;

  // Input actions
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_NEW_CONN = 1'b1;

  // Result kinds
  localparam logic [2:0] K_TEXT       = 3'd0;
  localparam logic [2:0] K_TEXT_END   = 3'd1;
  localparam logic [2:0] K_PONG       = 3'd2;
  localparam logic [2:0] K_PONG_EMPTY = 3'd3;
  localparam logic [2:0] K_CLOSE      = 3'd4;
  localparam logic [2:0] K_ERROR      = 3'd5;

  // Frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Length codes and limits
  localparam logic [6:0]  LEN_CODE16   = 7'd126;
  localparam logic [6:0]  LEN_CODE64   = 7'd127;
  localparam logic [31:0] CTL_MAX_LEN  = 32'd125;
  localparam logic [31:0] MAX_MSG_RESET = 32'd8388608;

  // Header byte counter marks
  localparam logic [2:0] EXT16_START = 3'd6;
  localparam logic [2:0] EXT_LAST    = 3'd7;
  localparam logic [2:0] MASK_LAST   = 3'd3;

endpackage

@@ rtl/wsfr_in_reg.sv @@
// Input register stage of the websocket frame receiver.
module wsfr_in_reg
  import wsfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     held_vld,
  output in_item_t held_item
);

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;
  logic     load;

  // Stall only when the held item cannot move on this cycle
  assign in_stall = vld_r & ~advance;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture the item on accept
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign held_vld  = vld_r;
  assign held_item = item_r;

endmodule

@@ rtl/wsfr_parser.sv @@
// Frame header parser, payload unmasker and fragment tracker.
module wsfr_parser
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    item,
  input  logic [31:0] max_len,
  output result_t     res
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DEAD    = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic        mask_on_r, mask_on_nxt;
  logic [63:0] hlen_r, hlen_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [31:0] mkey_r, mkey_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  logic        frag_open_r, frag_open_nxt;
  logic [31:0] frag_total_r, frag_total_nxt;

  logic [7:0]  b;
  logic [63:0] len_ext;
  logic [63:0] len_hdr1;
  logic [63:0] len_cur;
  logic        len_hi_nz;
  logic [31:0] len_lo;
  logic        ctl_bad;
  logic        too_long;
  logic [31:0] he_len;
  logic        he_zero;
  logic [32:0] frag_sum;
  logic        frag_over;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic        fin_byte;
  logic        do_ldone;
  logic        do_hend;
  logic        do_fail;

  // Length candidates and checks
  assign b         = item.data_byte;
  assign len_ext   = {hlen_r[55:0], b};
  assign len_hdr1  = {57'd0, b[6:0]};
  assign len_cur   = (phase_r == PH_EXTLEN) ? len_ext : len_hdr1;
  assign len_hi_nz = |len_cur[63:32];
  assign len_lo    = len_cur[31:0];
  assign ctl_bad   = opc_r[3] & (~fin_r | len_hi_nz | (len_lo > CTL_MAX_LEN));
  assign too_long  = len_hi_nz | (len_lo > max_len);
  assign he_len    = (phase_r == PH_MASK) ? hlen_r[31:0] : len_lo;
  assign he_zero   = (he_len == 32'd0);
  assign frag_sum  = {1'b0, frag_total_r} + {1'b0, he_len};
  assign frag_over = frag_sum > {1'b0, max_len};

  // Mask key byte for this payload position
  always_comb begin
    unique case (bidx_r)
      2'd0:    key_byte = mkey_r[31:24];
      2'd1:    key_byte = mkey_r[23:16];
      2'd2:    key_byte = mkey_r[15:8];
      default: key_byte = mkey_r[7:0];
    endcase
  end

  assign plain    = mask_on_r ? (b ^ key_byte) : b;
  assign fin_byte = (remain_r == 32'd1);

  // Next state and result
  always_comb begin
    phase_nxt      = phase_r;
    fin_nxt        = fin_r;
    opc_nxt        = opc_r;
    mask_on_nxt    = mask_on_r;
    hlen_nxt       = hlen_r;
    hcnt_nxt       = hcnt_r;
    mkey_nxt       = mkey_r;
    remain_nxt     = remain_r;
    bidx_nxt       = bidx_r;
    frag_open_nxt  = frag_open_r;
    frag_total_nxt = frag_total_r;
    res            = '0;
    do_ldone       = 1'b0;
    do_hend        = 1'b0;
    do_fail        = 1'b0;

    if (item.action == ACT_NEW_CONN) begin
      // Clear the connection
      phase_nxt      = PH_HDR0;
      fin_nxt        = 1'b0;
      opc_nxt        = 4'h0;
      mask_on_nxt    = 1'b0;
      hlen_nxt       = '0;
      hcnt_nxt       = '0;
      mkey_nxt       = '0;
      remain_nxt     = '0;
      bidx_nxt       = '0;
      frag_open_nxt  = 1'b0;
      frag_total_nxt = '0;
    end else begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt   = b[7];
          opc_nxt   = b[3:0];
          hcnt_nxt  = (|b[6:4]) ? 3'd1 : 3'd0;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          if (hcnt_r != 3'd0) begin
            do_fail = 1'b1;
          end else begin
            mask_on_nxt = b[7];
            hlen_nxt    = len_hdr1;
            hcnt_nxt    = 3'd0;
            if (b[6:0] == LEN_CODE16 || b[6:0] == LEN_CODE64) begin
              hcnt_nxt  = (b[6:0] == LEN_CODE16) ? EXT16_START : 3'd0;
              hlen_nxt  = '0;
              phase_nxt = PH_EXTLEN;
            end else begin
              do_ldone = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          hlen_nxt = len_ext;
          if (hcnt_r >= EXT_LAST) begin
            do_ldone = 1'b1;
          end else begin
            hcnt_nxt = hcnt_r + 3'd1;
          end
        end
        PH_MASK: begin
          mkey_nxt = {mkey_r[23:0], b};
          if (hcnt_r >= MASK_LAST) begin
            do_hend = 1'b1;
          end else begin
            hcnt_nxt = hcnt_r + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          remain_nxt = remain_r - 32'd1;
          bidx_nxt   = bidx_r + 2'd1;
          if (fin_byte) begin
            phase_nxt = PH_HDR0;
          end
          if (opc_r == OP_CONT || opc_r == OP_TEXT) begin
            if (fin_byte && fin_r && opc_r == OP_CONT) begin
              frag_open_nxt  = 1'b0;
              frag_total_nxt = '0;
            end
            res.vld       = 1'b1;
            res.item.kind = K_TEXT;
            res.item.data = plain;
            res.item.last = fin_byte & fin_r;
          end else if (opc_r == OP_CLOSE) begin
            if (fin_byte) begin
              phase_nxt     = PH_DEAD;
              res.vld       = 1'b1;
              res.item.kind = K_CLOSE;
            end
          end else if (opc_r == OP_PING) begin
            res.vld              = 1'b1;
            res.item.kind        = K_PONG;
            res.item.data        = plain;
            res.item.last        = fin_byte;
            res.item.ping_length = hlen_r[6:0];
          end
        end
        default: begin
          // Dead connection: drop the byte
        end
      endcase

      // Length complete
      if (do_ldone) begin
        if (ctl_bad || too_long) begin
          do_fail = 1'b1;
        end else if (mask_on_nxt) begin
          hcnt_nxt  = 3'd0;
          mkey_nxt  = '0;
          phase_nxt = PH_MASK;
        end else begin
          do_hend = 1'b1;
        end
      end

      // Header complete
      if (do_hend) begin
        remain_nxt = he_len;
        bidx_nxt   = 2'd0;
        phase_nxt  = he_zero ? PH_HDR0 : PH_PAYLOAD;
        unique case (opc_r)
          OP_TEXT: begin
            if (frag_open_r) begin
              do_fail = 1'b1;
            end else if (!fin_r) begin
              frag_open_nxt  = 1'b1;
              frag_total_nxt = he_len;
            end else if (he_zero) begin
              res.vld       = 1'b1;
              res.item.kind = K_TEXT_END;
              res.item.last = 1'b1;
            end
          end
          OP_CONT: begin
            if (!frag_open_r || frag_over) begin
              do_fail = 1'b1;
            end else begin
              frag_total_nxt = frag_sum[31:0];
              if (he_zero && fin_r) begin
                frag_open_nxt  = 1'b0;
                frag_total_nxt = '0;
                res.vld        = 1'b1;
                res.item.kind  = K_TEXT_END;
                res.item.last  = 1'b1;
              end
            end
          end
          OP_CLOSE: begin
            frag_open_nxt  = 1'b0;
            frag_total_nxt = '0;
            if (he_zero) begin
              phase_nxt     = PH_DEAD;
              res.vld       = 1'b1;
              res.item.kind = K_CLOSE;
            end
          end
          OP_PING: begin
            if (he_zero) begin
              res.vld       = 1'b1;
              res.item.kind = K_PONG_EMPTY;
              res.item.last = 1'b1;
            end
          end
          OP_PONG: begin
            // Drop pong frames
          end
          default: begin
            do_fail = 1'b1;
          end
        endcase
      end

      // Protocol error: drop fragments and go dead
      if (do_fail) begin
        frag_open_nxt  = 1'b0;
        frag_total_nxt = '0;
        phase_nxt      = PH_DEAD;
        res            = '0;
        res.vld        = 1'b1;
        res.item.kind  = K_ERROR;
      end
    end
  end

  // Advance state when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR0;
      fin_r        <= 1'b0;
      opc_r        <= 4'h0;
      mask_on_r    <= 1'b0;
      hlen_r       <= '0;
      hcnt_r       <= '0;
      mkey_r       <= '0;
      remain_r     <= '0;
      bidx_r       <= '0;
      frag_open_r  <= 1'b0;
      frag_total_r <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      fin_r        <= fin_nxt;
      opc_r        <= opc_nxt;
      mask_on_r    <= mask_on_nxt;
      hlen_r       <= hlen_nxt;
      hcnt_r       <= hcnt_nxt;
      mkey_r       <= mkey_nxt;
      remain_r     <= remain_nxt;
      bidx_r       <= bidx_nxt;
      frag_open_r  <= frag_open_nxt;
      frag_total_r <= frag_total_nxt;
    end
  end

  a_closed_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !frag_open_r |-> frag_total_r == 32'd0)
    else $error("fragment total nonzero with no open message");

  a_payload_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != 32'd0)
    else $error("payload phase with no bytes remaining");

  a_dead_no_fragment: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD |-> !frag_open_r)
    else $error("dead connection still holds an open message");

  a_error_goes_dead: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.vld && res.item.kind == K_ERROR |=> phase_r == PH_DEAD)
    else $error("error result without entering dead phase");

endmodule

@@ rtl/wsfr_out_reg.sv @@
// Result register stage of the websocket frame receiver.
module wsfr_out_reg
  import wsfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  result_t   res,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      vld_r;
  logic      vld_nxt;
  out_item_t item_r;

  // Slot frees when empty or being taken this cycle
  assign out_free = ~vld_r | ~out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = res.vld;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load a new result
  always_ff @(posedge clk) begin
    if (advance && res.vld) begin
      item_r <= res.item;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

@@ rtl/websocket_frame_receiver.sv @@
// Top level of the websocket frame receiver: register stages, parser, config register.
//
// Takes one received byte (or a new-connection command) per cycle while in_stall
// is low and gives at most one result per byte. An accepted item is held in the
// input register, then passes through the header/payload parser into the result
// register once the result slot is free; that register holds it until it is taken.
// Throughput is one item per cycle while the result register is not stalled,
// limited by the single parser state update per byte; the input stalls only when
// the input register is occupied and the result register is full and stalled.
// Errors are flagged while the header is parsed, so on an error result the
// consumer drops any partly delivered text message. The user must write the
// max_message_bytes register through cfg_valid/cfg_ready/cfg_data only while no
// item is in flight; the block itself does not enforce this.
module websocket_frame_receiver
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic        cfg_write;
  logic [31:0] max_msg_r;
  logic        held_vld;
  in_item_t    held_item;
  logic        out_free;
  logic        advance;
  result_t     res;

  // Config register always takes writes
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_r <= MAX_MSG_RESET;
    end else if (cfg_write) begin
      max_msg_r <= cfg_data;
    end
  end

  // Move the held item when the result slot is free
  assign advance = held_vld & out_free;

  wsfr_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .advance   (advance),
    .held_vld  (held_vld),
    .held_item (held_item)
  );

  wsfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (held_item),
    .max_len (max_msg_r),
    .res     (res)
  );

  wsfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
